// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the key press classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop at every rising clock edge outside reset.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check prop at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLKD(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// File: rtl/tkpc_pkg.sv
// Package with types and constants of the three key press classifier.
package tkpc_pkg;

    localparam int NUM_KEYS  = 3;
    localparam int KEY_MINUS = 0;
    localparam int KEY_PLUS  = 1;
    localparam int KEY_START = 2;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int DT_W      = 4;
    localparam int SPEED_W   = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_MIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_MAX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MAX  = 3'd5;

    // Register values after reset.
    localparam logic [CFG_W-1:0] RST_SHORT_MIN  = 16'd5;
    localparam logic [CFG_W-1:0] RST_LONG_MIN   = 16'd150;
    localparam logic [CFG_W-1:0] RST_LONG_MAX   = 16'd300;
    localparam logic [CFG_W-1:0] RST_SPEED_STEP = 16'd100;
    localparam logic [CFG_W-1:0] RST_SPEED_MIN  = 16'd0;
    localparam logic [CFG_W-1:0] RST_SPEED_MAX  = 16'hFFFF;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    typedef struct packed {
        logic [CFG_W-1:0] short_min;
        logic [CFG_W-1:0] long_min;
        logic [CFG_W-1:0] long_max;
    } timing_cfg_t;

    typedef struct packed {
        logic [CFG_W-1:0] step;
        logic [CFG_W-1:0] lo;
        logic [CFG_W-1:0] hi;
    } speed_cfg_t;

    typedef struct packed {
        logic click;
        logic long_press;
    } key_event_t;

    // Packed so that speed_setting lands in the lowest bits.
    typedef struct packed {
        logic               setting_changed;
        logic               beep_pulse;
        logic               run_active;
        logic [SPEED_W-1:0] speed_setting;
    } result_t;

    localparam int RESULT_W  = $bits(result_t);
    localparam int OUT_PAD_W = OUT_TDATA_W - RESULT_W;

endpackage

// File: rtl/tkpc_lane.sv
// One key lane: press timer, press and long press flags, event detection.
`include "assert_macros.svh"

module tkpc_lane
    import tkpc_pkg::*;
#(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                key_level,
    input  logic [DT_W-1:0]     dt,
    input  timing_cfg_t         tcfg,
    output key_event_t          ev
);

    localparam int CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

    logic [TIMER_WIDTH-1:0] timer_reg, timer_next;
    logic                   seen_reg, seen_next;
    logic                   long_reg, long_next;

    logic [TIMER_WIDTH:0]   sum;
    logic [TIMER_WIDTH-1:0] timer_upd;
    logic                   counting;
    logic                   seen_upd;
    logic [CMP_W-1:0]       t_ext;
    logic [CMP_W-1:0]       smin_ext, lmin_ext, lmax_ext;

    always_comb begin
        counting  = key_level && !long_reg;
        sum       = {1'b0, timer_reg} + (TIMER_WIDTH+1)'(dt);
        timer_upd = timer_reg;
        if (counting) begin
            timer_upd = sum[TIMER_WIDTH] ? '1 : sum[TIMER_WIDTH-1:0];
        end
        seen_upd = seen_reg || counting;
        t_ext    = CMP_W'(timer_upd);
        smin_ext = CMP_W'(tcfg.short_min);
        lmin_ext = CMP_W'(tcfg.long_min);
        lmax_ext = CMP_W'(tcfg.long_max);

        ev.click      = seen_upd && !key_level && (t_ext > smin_ext) && (t_ext < lmin_ext);
        ev.long_press = seen_upd && key_level && !long_reg
                        && (t_ext > lmin_ext) && (t_ext < lmax_ext);

        if (seen_upd && !key_level) begin
            timer_next = '0;
            seen_next  = 1'b0;
            long_next  = 1'b0;
        end else begin
            timer_next = timer_upd;
            seen_next  = seen_upd;
            long_next  = long_reg || ev.long_press;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_reg <= '0;
            seen_reg  <= 1'b0;
            long_reg  <= 1'b0;
        end else if (en) begin
            timer_reg <= timer_next;
            seen_reg  <= seen_next;
            long_reg  <= long_next;
        end
    end

    `ASSERT_CLKD(a_long_needs_press, aclk, aresetn, long_reg |-> seen_reg, "long press flag without press")
    `ASSERT_CLKD(a_event_excl, aclk, aresetn, !(ev.click && ev.long_press), "click and long press together")
    `ASSERT_CLKD(a_timer_frozen, aclk, aresetn, $past(aresetn && en && long_reg && key_level) |-> (timer_reg == $past(timer_reg)), "timer moved after long press")

endmodule

// File: rtl/tkpc_merge.sv
// Merge stage: combine lane events into speed setpoint, run flag and pulses.
module tkpc_merge
    import tkpc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  key_event_t [NUM_KEYS-1:0] ev,
    input  speed_cfg_t           scfg,
    output result_t              res
);

    logic [SPEED_W-1:0] speed_reg, speed_next;
    logic               run_reg, run_next;
    logic [SPEED_W-1:0] speed_dec;
    logic [SPEED_W-1:0] speed_a;
    logic [SPEED_W:0]   speed_sum;

    always_comb begin
        // Minus first, floor only.
        speed_dec = speed_reg - scfg.step;
        speed_a   = speed_reg;
        if (ev[KEY_MINUS].click) begin
            if ((speed_reg < scfg.step) || (speed_dec < scfg.lo)) begin
                speed_a = scfg.lo;
            end else begin
                speed_a = speed_dec;
            end
        end
        // Plus on the result of minus, ceiling only.
        speed_sum  = {1'b0, speed_a} + {1'b0, scfg.step};
        speed_next = speed_a;
        if (ev[KEY_PLUS].click) begin
            speed_next = (speed_sum > {1'b0, scfg.hi}) ? scfg.hi : speed_sum[SPEED_W-1:0];
        end
        run_next = run_reg ^ ev[KEY_START].click;

        res.speed_setting   = speed_next;
        res.run_active      = run_next;
        res.beep_pulse      = |ev;
        res.setting_changed = ev[KEY_MINUS].click || ev[KEY_PLUS].click;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg <= '0;
            run_reg   <= 1'b0;
        end else if (en) begin
            speed_reg <= speed_next;
            run_reg   <= run_next;
        end
    end

endmodule

// File: rtl/three_key_press_classifier.sv
// Top level of the three key press classifier: lanes, merge and output buffer.
//
// Usage: each word on the s_ channel is one scan tick with the minus, plus
// and start key levels and the ticks elapsed since the last scan. Each
// accepted word yields exactly one result word on the m_ channel carrying
// the speed setpoint, the run flag, a beep pulse and a setting change pulse.
// Three key lanes evaluate their press timers side by side in the cycle the
// word is accepted; the merge stage applies minus, then plus, then start.
// An accepted word's result is registered in the output register, or in the
// skid register while the output stalls. Throughput: one word per cycle
// while skid is free; lane compare and the merge clamp are combinational.
// Backpressure: an output register and a one-word skid register sit behind
// the merge stage, so s_tready stays high while one result waits for the
// receiver and drops only when both hold words.
// Reset (aresetn low, synchronous): timers, flags, speed and run clear, the
// configuration registers return to their defaults, both buffers empty.
// Configuration: cfg_we writes cfg_wdata into register cfg_index; indexes
// past the last register are ignored. Write only while the block is idle.
`include "assert_macros.svh"

module three_key_press_classifier
    import tkpc_pkg::*;
#(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input scan words
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [0] minus_down, [1] plus_down, [2] start_down, [6:3] elapsed_ticks, [7] zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // Result words
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [15:0] speed_setting, [16] run_active, [17] beep_pulse,
    // [18] setting_changed, [23:19] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // Configuration writes
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_wdata
);

    logic [CFG_W-1:0] short_min_reg, long_min_reg, long_max_reg;
    logic [CFG_W-1:0] step_reg, speed_min_reg, speed_max_reg;

    timing_cfg_t tcfg;
    speed_cfg_t  scfg;

    logic                  push;
    logic                  pop;
    logic [NUM_KEYS-1:0]   keys;
    logic [DT_W-1:0]       dt;
    key_event_t [NUM_KEYS-1:0] ev;
    result_t               res;

    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg, skid_data_next;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_min_reg <= RST_SHORT_MIN;
            long_min_reg  <= RST_LONG_MIN;
            long_max_reg  <= RST_LONG_MAX;
            step_reg      <= RST_SPEED_STEP;
            speed_min_reg <= RST_SPEED_MIN;
            speed_max_reg <= RST_SPEED_MAX;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SHORT_MIN:  short_min_reg <= cfg_wdata;
                CFG_LONG_MIN:   long_min_reg  <= cfg_wdata;
                CFG_LONG_MAX:   long_max_reg  <= cfg_wdata;
                CFG_SPEED_STEP: step_reg      <= cfg_wdata;
                CFG_SPEED_MIN:  speed_min_reg <= cfg_wdata;
                CFG_SPEED_MAX:  speed_max_reg <= cfg_wdata;
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    assign tcfg.short_min = short_min_reg;
    assign tcfg.long_min  = long_min_reg;
    assign tcfg.long_max  = long_max_reg;
    assign scfg.step      = step_reg;
    assign scfg.lo        = speed_min_reg;
    assign scfg.hi        = speed_max_reg;

    // Unpack the scan word
    assign keys = s_tdata[NUM_KEYS-1:0];
    assign dt   = s_tdata[NUM_KEYS +: DT_W];

    // Accept whenever the skid register is free
    assign s_tready = !skid_valid_reg;
    assign push     = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;

    // One lane per key
    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        tkpc_lane #(
            .TIMER_WIDTH (TIMER_WIDTH)
        ) u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (push),
            .key_level (keys[k]),
            .dt        (dt),
            .tcfg      (tcfg),
            .ev        (ev[k])
        );
    end

    tkpc_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (push),
        .ev      (ev),
        .scfg    (scfg),
        .res     (res)
    );

    // Output register plus skid: refill the output from skid first, then from
    // the merge stage; park a new word in skid while the output is stalled.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next  = push;
                out_data_next   = res;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_data_reg};

    `ASSERT_CLKD(a_skid_behind_out, aclk, aresetn, skid_valid_reg |-> out_valid_reg, "skid word with empty output")
    `ASSERT_CLKD(a_change_beeps, aclk, aresetn, (out_valid_reg && out_data_reg.setting_changed) |-> out_data_reg.beep_pulse, "setting change without beep")
    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> (!m_tvalid && s_tready), "buffers not empty after reset")

endmodule

// File: dv/tb.sv
// Self-checking testbench for the three key press classifier: scan words in, setpoints out.
`timescale 1ns / 1ps

module tb;
    import tkpc_pkg::*;

    localparam int TMR_W      = 16;
    localparam int IDLE_PCT   = 38;   // chance in a hundred that a side idles
    localparam int MAX_SHOWN  = 10;   // mismatches printed in full
    localparam int LONG_HOLDS = 40;   // 15-tick scans held with no long window

    // Indexes past the last register; the block must ignore writes to them.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;

    always #1 aclk = ~aclk;

    three_key_press_classifier #(
        .TIMER_WIDTH(TMR_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // Scan words waiting for the driver, and setpoints waiting for the block.
    logic [IN_TDATA_W-1:0] scan_q[$];
    result_t               setpoint_q[$];

    bit calm       = 1'b0;  // set: neither side idles
    bit word_taken = 1'b0;  // s_ handshake completed at the last rising edge
    int mismatches = 0;

    // Shadow of the block's state and registers.
    logic [TMR_W-1:0]   hold_ticks[NUM_KEYS];
    bit                 held[NUM_KEYS];
    bit                 long_hit[NUM_KEYS];
    logic [SPEED_W-1:0] speed_now;
    bit                 running;
    timing_cfg_t        win;
    speed_cfg_t         spd;

    function automatic void flag_error(string msg);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("%0t mismatch: %s", $realtime, msg);
    endfunction

    // Advance one key's press timer and classify a release or a long hold.
    function automatic key_event_t time_key(int k, bit down, logic [DT_W-1:0] dt);
        key_event_t     ev;
        logic [TMR_W:0] sum;
        ev = '0;
        // Count only while held and not yet flagged long; pin at the top value.
        if (down && !long_hit[k]) begin
            sum = {1'b0, hold_ticks[k]} + dt;
            hold_ticks[k] = sum[TMR_W] ? {TMR_W{1'b1}} : sum[TMR_W-1:0];
            held[k] = 1'b1;
        end
        if (held[k]) begin
            if (!down) begin
                if (hold_ticks[k] > win.short_min && hold_ticks[k] < win.long_min)
                    ev.click = 1'b1;
                held[k]       = 1'b0;
                long_hit[k]   = 1'b0;
                hold_ticks[k] = '0;
            end
            // Flag a long press once; the timer then stays frozen until release.
            if (hold_ticks[k] > win.long_min && hold_ticks[k] < win.long_max &&
                !long_hit[k]) begin
                long_hit[k]   = 1'b1;
                ev.long_press = 1'b1;
            end
        end
        return ev;
    endfunction

    // Work out the setpoint word that one scan word produces; keys go minus, plus, start.
    function automatic result_t classify_scan(logic [IN_TDATA_W-1:0] word);
        key_event_t       ev;
        result_t          r;
        logic [DT_W-1:0]  dt;
        logic [SPEED_W:0] sum;
        dt = word[DT_W+2:3];
        r  = '0;

        ev = time_key(KEY_MINUS, word[KEY_MINUS], dt);
        if (ev.click || ev.long_press)
            r.beep_pulse = 1'b1;
        if (ev.click) begin
            // Floor only; a speed above the ceiling may stay there.
            if (speed_now < spd.step || speed_now - spd.step < spd.lo)
                speed_now = spd.lo;
            else
                speed_now = speed_now - spd.step;
            r.setting_changed = 1'b1;
        end

        ev = time_key(KEY_PLUS, word[KEY_PLUS], dt);
        if (ev.click || ev.long_press)
            r.beep_pulse = 1'b1;
        if (ev.click) begin
            // Ceiling only, computed one bit wider so that nothing wraps.
            sum = {1'b0, speed_now} + spd.step;
            speed_now = (sum > {1'b0, spd.hi}) ? spd.hi : sum[SPEED_W-1:0];
            r.setting_changed = 1'b1;
        end

        ev = time_key(KEY_START, word[KEY_START], dt);
        if (ev.click || ev.long_press)
            r.beep_pulse = 1'b1;
        if (ev.click)
            running = ~running;

        r.speed_setting = speed_now;
        r.run_active    = running;
        return r;
    endfunction

    // Driver: hold a word until it is taken, then advance or idle.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || word_taken) begin
            if (scan_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= scan_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random unless in a calm stretch.
    always @(negedge aclk) begin
        m_tready <= aresetn && (calm || $urandom_range(0, 99) >= IDLE_PCT);
    end

    // Monitor: track register writes, check results, predict on accepted scans.
    always @(posedge aclk) begin : watch
        result_t got;
        result_t want;
        word_taken <= aresetn && s_tvalid && s_tready;
        if (!aresetn) begin
            foreach (hold_ticks[k]) begin
                hold_ticks[k] = '0;
                held[k]       = 1'b0;
                long_hit[k]   = 1'b0;
            end
            speed_now = '0;
            running   = 1'b0;
            win = '{short_min: RST_SHORT_MIN, long_min: RST_LONG_MIN, long_max: RST_LONG_MAX};
            spd = '{step: RST_SPEED_STEP, lo: RST_SPEED_MIN, hi: RST_SPEED_MAX};
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SHORT_MIN:  win.short_min = cfg_wdata;
                    CFG_LONG_MIN:   win.long_min  = cfg_wdata;
                    CFG_LONG_MAX:   win.long_max  = cfg_wdata;
                    CFG_SPEED_STEP: spd.step      = cfg_wdata;
                    CFG_SPEED_MIN:  spd.lo        = cfg_wdata;
                    CFG_SPEED_MAX:  spd.hi        = cfg_wdata;
                    default: ;  // drop writes to unknown indexes
                endcase
            end
            // Check before predicting: this edge's result belongs to an older scan.
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[RESULT_W-1:0]);
                if (setpoint_q.size() == 0) begin
                    flag_error($sformatf("unexpected result word %h", m_tdata));
                end else begin
                    want = setpoint_q.pop_front();
                    if (got.speed_setting !== want.speed_setting ||
                        got.run_active !== want.run_active ||
                        got.beep_pulse !== want.beep_pulse ||
                        got.setting_changed !== want.setting_changed)
                        flag_error($sformatf(
                            "speed %0d/%0d run %b/%b beep %b/%b changed %b/%b (exp/got)",
                            want.speed_setting, got.speed_setting,
                            want.run_active, got.run_active,
                            want.beep_pulse, got.beep_pulse,
                            want.setting_changed, got.setting_changed));
                end
            end
            if (s_tvalid && s_tready)
                setpoint_q.push_back(classify_scan(s_tdata));
        end
    end

    task automatic push_scan(bit mn, bit pl, bit st, logic [DT_W-1:0] dt);
        scan_q.push_back({1'b0, dt, st, pl, mn});
    endtask

    // Queue press/release runs per key with random hold lengths, plus some noise.
    task automatic push_presses(int count, int max_hold);
        int              hold_left[NUM_KEYS];
        int              gap_left[NUM_KEYS];
        bit              lvl[NUM_KEYS];
        logic [DT_W-1:0] dt;
        foreach (hold_left[k]) begin
            hold_left[k] = 0;
            gap_left[k]  = 0;
        end
        repeat (count) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                if (hold_left[k] == 0 && gap_left[k] == 0) begin
                    hold_left[k] = $urandom_range(1, max_hold);
                    gap_left[k]  = $urandom_range(1, 4);
                end
                if (hold_left[k] != 0) begin
                    lvl[k] = 1'b1;
                    hold_left[k]--;
                end else begin
                    lvl[k] = 1'b0;
                    gap_left[k]--;
                end
            end
            // Break the runs now and then with random levels.
            if ($urandom_range(0, 9) == 0)
                foreach (lvl[k])
                    lvl[k] = 1'($urandom_range(0, 1));
            // Small steps hit the window edges more often.
            dt = ($urandom_range(0, 3) == 0) ? DT_W'($urandom_range(0, 2))
                                             : DT_W'($urandom_range(0, 15));
            push_scan(lvl[KEY_MINUS], lvl[KEY_PLUS], lvl[KEY_START], dt);
        end
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic load_regs(logic [CFG_W-1:0] short_min, logic [CFG_W-1:0] long_min,
                             logic [CFG_W-1:0] long_max, logic [CFG_W-1:0] step,
                             logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi);
        set_reg(CFG_SHORT_MIN, short_min);
        set_reg(CFG_LONG_MIN, long_min);
        set_reg(CFG_LONG_MAX, long_max);
        set_reg(CFG_SPEED_STEP, step);
        set_reg(CFG_SPEED_MIN, lo);
        set_reg(CFG_SPEED_MAX, hi);
    endtask

    // Wait until every queued word is taken and every setpoint has arrived.
    task automatic settle();
        int waited;
        while (scan_q.size() != 0 || s_tvalid)
            @(posedge aclk);
        waited = 0;
        while (setpoint_q.size() != 0 && waited < 1000) begin
            @(posedge aclk);
            waited++;
        end
        if (setpoint_q.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", setpoint_q.size()));
            setpoint_q.delete();
        end
        // Leave a little margin before touching registers.
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        logic [CFG_W-1:0] lo_edge;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed, reset registers (click window 6..149, long window 151..299).
        push_scan(0, 0, 0, 0);
        push_scan(1, 0, 0, 15);          // minus click at speed 0: held at the floor
        push_scan(0, 0, 0, 0);
        push_scan(0, 1, 0, 7);           // plus click
        push_scan(0, 0, 0, 0);
        push_scan(0, 0, 1, 15);          // start click toggles run
        push_scan(0, 0, 0, 3);
        repeat (12) push_scan(1, 1, 1, 15);  // all three go long at 165, then freeze
        push_scan(0, 0, 0, 15);          // release after long: no click
        push_scan(0, 1, 0, 0);           // press of zero length: no click
        push_scan(0, 0, 0, 0);
        push_scan(1, 1, 0, 6);           // minus and plus click together
        push_scan(0, 0, 0, 9);
        settle();

        push_presses(100, 40);
        settle();

        // Narrow windows with a long stretch of no idling.
        load_regs(2, 20, 45, 700, 300, 5000);
        calm = 1'b1;
        push_presses(100, 8);
        settle();
        calm = 1'b0;

        // Wide click window, full step: plus pins at the top, minus at zero.
        load_regs(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
        push_presses(40, 6);
        settle();

        // Crossed speed limits: floor above ceiling.
        load_regs(0, 10, 16'hFFFF, 1, 16'hFFFF, 16'h0000);
        push_presses(40, 6);
        settle();

        // Speed likely left outside a narrow band; only the named limit applies.
        load_regs(3, 30, 60, 250, 1000, 1200);
        push_presses(40, 8);
        settle();

        // All registers zero: empty windows, step of nothing.
        load_regs(0, 0, 0, 0, 0, 0);
        push_presses(20, 6);
        settle();

        // No long window: held timers keep counting and never freeze.
        load_regs(5, 16'hFFFF, 16'h0000, 100, 0, 16'hFFFF);
        repeat (LONG_HOLDS) push_scan(1, 1, 1, 15);
        push_scan(0, 0, 0, 15);          // release inside the wide click window: clicks
        settle();

        // Writes to unknown indexes must not disturb the registers.
        set_reg(CFG_SPARE_LO, CFG_W'($urandom_range(0, 16'hFFFF)));
        set_reg(CFG_SPARE_HI, CFG_W'($urandom_range(0, 16'hFFFF)));
        push_presses(20, 4);
        settle();

        // Random registers with windows narrow enough to see events.
        repeat (2) begin
            lo_edge = CFG_W'($urandom_range(0, 20));
            load_regs(lo_edge, CFG_W'(lo_edge + $urandom_range(0, 60)),
                      CFG_W'(lo_edge + $urandom_range(60, 160)),
                      CFG_W'($urandom_range(0, 16'hFFFF)), CFG_W'($urandom_range(0, 16'hFFFF)),
                      CFG_W'($urandom_range(0, 16'hFFFF)));
            push_presses(40, 15);
            settle();
        end

        if (mismatches == 0)
            $display("[three_key_press_classifier] OK");
        else
            $display("[three_key_press_classifier] ERROR");
        $finish;
    end

    // Hard stop well past the slowest correct run.
    initial begin
        #2_000_000;
        $display("[three_key_press_classifier] ERROR");
        $finish;
    end

endmodule
